// ----- rtl/mec_pkg.sv -----
package mec_pkg;

   localparam int DATA_W              = 64;
   localparam int HALF_W              = 32;
   localparam int ACC_W               = 128;
   localparam int CFG_W               = 16;
   localparam int COLOUR_W            = 8;
   localparam int ITER_W              = 16;
   localparam int FRAC_BITS_DEFAULT   = 58;
   localparam int COUNT_WIDTH_DEFAULT = 16;

   localparam logic [CFG_W-1:0] MAX_ITER_RESET = 16'd3000;

   localparam logic [1:0] SHIFT_NONE  = 2'd0;
   localparam logic [1:0] SHIFT_WORD  = 2'd1;
   localparam logic [1:0] SHIFT_DWORD = 2'd2;

   localparam logic [DATA_W-1:0] Q60_PI     = 64'h3243F6A8885A308D;
   localparam logic [DATA_W-1:0] Q60_SQRT2  = 64'h16A09E667F3BCC90;
   localparam logic [DATA_W-1:0] Q60_SQRTPI = 64'h1C5BF891B4EF6AA7;

   localparam logic [ACC_W-1:0] PI_SQRTPI_Q120 = {64'h0, Q60_PI} * {64'h0, Q60_SQRTPI};
   localparam logic [ACC_W-1:0] PI_SQRT2_Q120  = {64'h0, Q60_PI} * {64'h0, Q60_SQRT2};

   localparam logic [DATA_W-1:0] K_RED   = Q60_PI;
   localparam logic [DATA_W-1:0] K_GREEN = PI_SQRTPI_Q120[123:60];
   localparam logic [DATA_W-1:0] K_BLUE  = PI_SQRT2_Q120[123:60];

   typedef struct packed {
      logic              valid;
      logic              clear;
      logic              neg;
      logic [1:0]        shift;
   } mec_op_type;

   typedef struct packed {
      mec_op_type        op;
      logic [HALF_W-1:0] x;
      logic [HALF_W-1:0] y;
   } mec_issue_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] c_re;
      logic signed [DATA_W-1:0] c_im;
   } mec_req_type;

   typedef struct packed {
      logic [COLOUR_W-1:0] red;
      logic [COLOUR_W-1:0] green;
      logic [COLOUR_W-1:0] blue;
      logic                escaped;
      logic [ITER_W-1:0]   iteration_count;
   } mec_rsp_type;

endpackage

// ----- rtl/mec_mul_acc.sv -----
module mec_mul_acc
   import mec_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  mec_issue_type     issue,
   output logic [ACC_W-1:0]  acc
);

   logic [2*HALF_W-1:0] pp_ff, pp_in;
   mec_op_type          op_ff, op_in;
   logic [ACC_W-1:0]    acc_ff, acc_in;
   logic [ACC_W-1:0]    term;
   logic [ACC_W-1:0]    base;

   always_comb begin
      pp_in = (2*HALF_W)'(issue.x) * (2*HALF_W)'(issue.y);
      op_in = issue.op;
      case (op_ff.shift)
         SHIFT_NONE:  term = ACC_W'(pp_ff);
         SHIFT_WORD:  term = ACC_W'(pp_ff) << HALF_W;
         SHIFT_DWORD: term = ACC_W'(pp_ff) << (2*HALF_W);
         default:     term = '0;
      endcase
      base = op_ff.clear ? '0 : acc_ff;
      if (op_ff.valid) begin
         acc_in = op_ff.neg ? (base - term) : (base + term);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff <= '0;
      end else begin
         op_ff <= op_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff  <= pp_in;
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- rtl/mandelbrot_escape_colour_unit.sv -----
// Escape-time colouring of one complex point per request.
//
// req_*: one word holds the point c (c_re, c_im), signed fixed point with
// FRAC_BITS fraction bits. A word is taken when req_valid is high and
// req_stall is low; req_stall stays high from acceptance until the result
// has been handed to the output register.
// rsp_*: one word per request with the colour, the escape flag and the
// iteration count. rsp_valid holds, with the word unchanged, while rsp_stall
// is high; a new request is taken meanwhile, and its result waits in the
// core until the output register is free.
// csr_*: writes the iteration limit (reset value 3000); write only when idle.
// Every iteration runs four 32x32 partial products for each of a*a, b*b and
// a*b through the one shared multiply-accumulate unit. A point that escapes
// then runs two colour products for each of red, green and blue on the same
// multiplier; a point that reaches the limit L gets no colour products. The
// unit works on one point at a time: a new word is taken only once the
// previous result has been handed to the output register.
// Reset is synchronous and clears the sequencer, the output valid and the
// limit register; no word in flight survives it.
module mandelbrot_escape_colour_unit
   import mec_pkg::*;
#(
   parameter int FRAC_BITS   = FRAC_BITS_DEFAULT,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  mec_req_type       req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output mec_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [CFG_W-1:0]  csr_wdata
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_MAG  = 10'b0000000010,
      ST_SQA  = 10'b0000000100,
      ST_SQB  = 10'b0000001000,
      ST_TEST = 10'b0000010000,
      ST_REUP = 10'b0000100000,
      ST_MAB  = 10'b0001000000,
      ST_IMUP = 10'b0010000000,
      ST_COL  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } mec_state_type;

   localparam int               STEP_W   = 3;
   localparam logic [STEP_W-1:0] LAST_STEP  = 3'd4;
   localparam logic [STEP_W-1:0] PART_STEPS = 3'd4;
   localparam logic [STEP_W-1:0] COL_PARTS  = 3'd2;
   localparam logic [STEP_W-1:0] COL_READ   = 3'd3;
   localparam logic [1:0]       CH_RED   = 2'd0;
   localparam logic [1:0]       CH_GREEN = 2'd1;
   localparam logic [1:0]       CH_BLUE  = 2'd2;
   localparam int               ESC_POS  = 4 + 2*FRAC_BITS;
   localparam logic [ACC_W:0]   ESC_BOUND = (ACC_W+1)'(1) << ESC_POS;
   localparam logic [31:0]      CAP32 = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

   function automatic logic [DATA_W-1:0] mag64(input logic [DATA_W-1:0] v);
      return v[DATA_W-1] ? (DATA_W'(0) - v) : v;
   endfunction

   function automatic logic [DATA_W-1:0] sat64(input logic [ACC_W:0] v);
      logic fits;
      fits = (&v[ACC_W:DATA_W-1]) || !(|v[ACC_W:DATA_W-1]);
      if (fits) begin
         return v[DATA_W-1:0];
      end
      return v[ACC_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

   function automatic logic [COLOUR_W-1:0] mod255(input logic [19:0] w);
      logic [9:0] s1;
      logic [8:0] s2;
      s1 = 10'(w[19:16]) + 10'(w[15:8]) + 10'(w[7:0]);
      s2 = 9'(s1[9:8]) + 9'(s1[7:0]);
      return (s2 >= 9'd255) ? COLOUR_W'(s2 - 9'd255) : s2[7:0];
   endfunction

   function automatic mec_issue_type part(input logic [DATA_W-1:0] x,
                                          input logic [DATA_W-1:0] y,
                                          input logic [STEP_W-1:0] k,
                                          input logic neg);
      mec_issue_type r;
      r           = '0;
      r.op.valid  = 1'b1;
      r.op.neg    = neg;
      r.op.clear  = (k == '0);
      r.x         = k[1] ? x[DATA_W-1:HALF_W] : x[HALF_W-1:0];
      r.y         = k[0] ? y[DATA_W-1:HALF_W] : y[HALF_W-1:0];
      case (k[1:0])
         2'd0:    r.op.shift = SHIFT_NONE;
         2'd3:    r.op.shift = SHIFT_DWORD;
         default: r.op.shift = SHIFT_WORD;
      endcase
      return r;
   endfunction

   mec_state_type            state_ff, state_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [1:0]               ch_ff, ch_in;
   logic [DATA_W-1:0]        cr_ff, cr_in, ci_ff, ci_in;
   logic [DATA_W-1:0]        a_ff, a_in, b_ff, b_in;
   logic [DATA_W-1:0]        mag_a_ff, mag_a_in, mag_b_ff, mag_b_in;
   logic                     sgn_ff, sgn_in;
   logic [ACC_W-1:0]         hold_ff, hold_in, diff_ff, diff_in;
   logic [DATA_W-1:0]        re_ff, re_in;
   logic [COUNT_WIDTH-1:0]   n_ff, n_in, limit_ff, limit_in;
   logic                     esc_ff, esc_in;
   logic [COLOUR_W-1:0]      red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mec_rsp_type              rsp_ff, rsp_in;
   logic [CFG_W-1:0]         max_iter_ff, max_iter_in;

   mec_issue_type            issue;
   logic [ACC_W-1:0]         acc;
   logic [ACC_W:0]           mag_sum;
   logic signed [ACC_W-1:0]  re_shift, im_shift;
   logic [ACC_W:0]           re_sum, im_sum;
   logic [31:0]              lim32, n32;
   logic [COUNT_WIDTH-1:0]   n_inc;
   logic [DATA_W-1:0]        k_sel;
   logic [COLOUR_W-1:0]      chan;
   logic                     req_take, rsp_free;

   mec_mul_acc u_mul_acc (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .acc   (acc)
   );

   always_comb begin
      lim32    = (32'(max_iter_ff) < CAP32) ? 32'(max_iter_ff) : CAP32;
      n32      = 32'(n_ff);
      n_inc    = COUNT_WIDTH'(n_ff + 1'b1);
      mag_sum  = {1'b0, hold_ff} + {1'b0, acc};
      re_shift = $signed(diff_ff) >>> FRAC_BITS;
      im_shift = $signed(acc) >>> (FRAC_BITS - 1);
      re_sum   = {re_shift[ACC_W-1], re_shift} + {{(ACC_W-DATA_W+1){cr_ff[DATA_W-1]}}, cr_ff};
      im_sum   = {im_shift[ACC_W-1], im_shift} + {{(ACC_W-DATA_W+1){ci_ff[DATA_W-1]}}, ci_ff};
      chan     = mod255(acc[79:60]);
      case (ch_ff)
         CH_RED:   k_sel = K_RED;
         CH_GREEN: k_sel = K_GREEN;
         default:  k_sel = K_BLUE;
      endcase
      req_take = req_valid && !req_stall;
      rsp_free = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ch_in        = ch_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      sgn_in       = sgn_ff;
      hold_in      = hold_ff;
      diff_in      = diff_ff;
      re_in        = re_ff;
      n_in         = n_ff;
      limit_in     = limit_ff;
      esc_in       = esc_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      max_iter_in  = csr_we ? csr_wdata : max_iter_ff;
      issue        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               cr_in    = req_data.c_re;
               ci_in    = req_data.c_im;
               a_in     = req_data.c_re;
               b_in     = req_data.c_im;
               n_in     = '0;
               limit_in = COUNT_WIDTH'(lim32);
               esc_in   = 1'b0;
               red_in   = '0;
               green_in = '0;
               blue_in  = '0;
               state_in = (lim32 == '0) ? ST_DONE : ST_MAG;
            end
         end
         ST_MAG: begin
            mag_a_in = mag64(a_ff);
            mag_b_in = mag64(b_ff);
            sgn_in   = a_ff[DATA_W-1] ^ b_ff[DATA_W-1];
            step_in  = '0;
            state_in = ST_SQA;
         end
         ST_SQA: begin
            if (step_ff < PART_STEPS) begin
               issue = part(mag_a_ff, mag_a_ff, step_ff, 1'b0);
            end
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_SQB;
            end
         end
         ST_SQB: begin
            if (step_ff == '0) begin
               hold_in = acc;
            end
            if (step_ff < PART_STEPS) begin
               issue = part(mag_b_ff, mag_b_ff, step_ff, 1'b0);
            end
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_TEST;
            end
         end
         ST_TEST: begin
            diff_in = hold_ff - acc;
            if (mag_sum > ESC_BOUND) begin
               esc_in   = 1'b1;
               ch_in    = CH_RED;
               step_in  = '0;
               state_in = ST_COL;
            end else begin
               state_in = ST_REUP;
            end
         end
         ST_REUP: begin
            re_in    = sat64(re_sum);
            step_in  = '0;
            state_in = ST_MAB;
         end
         ST_MAB: begin
            if (step_ff < PART_STEPS) begin
               issue = part(mag_a_ff, mag_b_ff, step_ff, sgn_ff);
            end
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == LAST_STEP) begin
               step_in  = '0;
               state_in = ST_IMUP;
            end
         end
         ST_IMUP: begin
            a_in     = re_ff;
            b_in     = sat64(im_sum);
            n_in     = n_inc;
            state_in = (n_inc == limit_ff) ? ST_DONE : ST_MAG;
         end
         ST_COL: begin
            if (step_ff < COL_PARTS) begin
               issue.op.valid = 1'b1;
               issue.op.clear = (step_ff == '0);
               issue.op.shift = step_ff[0] ? SHIFT_WORD : SHIFT_NONE;
               issue.x        = HALF_W'(n32);
               issue.y        = step_ff[0] ? k_sel[DATA_W-1:HALF_W] : k_sel[HALF_W-1:0];
            end
            step_in = STEP_W'(step_ff + 1'b1);
            if (step_ff == COL_READ) begin
               step_in = '0;
               case (ch_ff)
                  CH_RED:   red_in   = chan;
                  CH_GREEN: green_in = chan;
                  default:  blue_in  = chan;
               endcase
               if (ch_ff == CH_BLUE) begin
                  state_in = ST_DONE;
               end else begin
                  ch_in = 2'(ch_ff + 1'b1);
               end
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_in.red             = red_ff;
               rsp_in.green           = green_ff;
               rsp_in.blue            = blue_ff;
               rsp_in.escaped         = esc_ff;
               rsp_in.iteration_count = n32[ITER_W-1:0];
               rsp_valid_in           = 1'b1;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         ch_ff        <= CH_RED;
         rsp_valid_ff <= 1'b0;
         max_iter_ff  <= MAX_ITER_RESET;
         n_ff         <= '0;
         limit_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ch_ff        <= ch_in;
         rsp_valid_ff <= rsp_valid_in;
         max_iter_ff  <= max_iter_in;
         n_ff         <= n_in;
         limit_ff     <= limit_in;
      end
   end

   always_ff @(posedge clock) begin
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      mag_a_ff <= mag_a_in;
      mag_b_ff <= mag_b_in;
      sgn_ff   <= sgn_in;
      hold_ff  <= hold_in;
      diff_ff  <= diff_in;
      re_ff    <= re_in;
      esc_ff   <= esc_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_accept_next: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_MAG || state_ff == ST_DONE)
      else $error("accepted word did not start the sequencer");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> n_ff <= limit_ff)
      else $error("iteration count passed the limit");

   a_black_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.escaped |->
         rsp_ff.red == '0 && rsp_ff.green == '0 && rsp_ff.blue == '0)
      else $error("point inside the set carries a colour");

   a_done_escape: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE && esc_ff |->
         $past(state_ff) == ST_COL || $past(state_ff) == ST_DONE)
      else $error("escaped word skipped the colour products");

endmodule
